// ----- rtl/e2rm_pkg.sv -----
// Shared constants, types and helper functions for the Euler-angle to
// rotation-matrix pipeline (euler_to_rotation_matrix).
// No dependencies.
`default_nettype none

package e2rm_pkg;

    // Angle resolution: 2^ANGLE_BITS units per turn. Matrix fraction bits.
    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // Fixed port field widths
    localparam int ANG_IN_W = 16;
    localparam int SHIFT_W  = 32;
    localparam int ENT_W    = 18;
    localparam int N_ENT    = 9;
    localparam int IN_W     = 3 * ANG_IN_W + 3 * SHIFT_W;
    localparam int OUT_RAW  = N_ENT * ENT_W + 3 * SHIFT_W;
    localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;
    localparam int TR_W     = 3 * SHIFT_W;

    // Angle folding
    localparam int U_W  = ANGLE_BITS - 2;
    localparam int TP_W = ANGLE_BITS + 33;
    localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);
    localparam logic [U_W-1:0] EIGHTH = U_W'(1) << (ANGLE_BITS - 3);
    localparam logic [TP_W-1:0] TWO_PI_Q32 = TP_W'(64'd26986075409);
    localparam logic [TP_W-1:0] HALF_UNIT = TP_W'(1) << (ANGLE_BITS - 1);

    // Q0.32 arithmetic
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [63:0] ONE_64    = 64'h1_0000_0000;
    localparam logic [33:0] ROUND_Q32 = 34'(1) << (31 - FRAC_BITS);

    // Horner step divisors and their floor reciprocals (scaled by 2^32)
    localparam int N_STEP = 7;
    localparam logic [7:0] DIV_COS [N_STEP] = '{8'd182, 8'd132, 8'd90, 8'd56,
                                                8'd30, 8'd12, 8'd2};
    localparam logic [31:0] RCP_COS [N_STEP] = '{
        32'(ONE_64 / 64'd182), 32'(ONE_64 / 64'd132), 32'(ONE_64 / 64'd90),
        32'(ONE_64 / 64'd56),  32'(ONE_64 / 64'd30),  32'(ONE_64 / 64'd12),
        32'(ONE_64 / 64'd2)};
    localparam logic [7:0] DIV_SIN [1:6] = '{8'd156, 8'd110, 8'd72, 8'd42,
                                             8'd20, 8'd6};
    localparam logic [31:0] RCP_SIN [1:6] = '{
        32'(ONE_64 / 64'd156), 32'(ONE_64 / 64'd110), 32'(ONE_64 / 64'd72),
        32'(ONE_64 / 64'd42),  32'(ONE_64 / 64'd20),  32'(ONE_64 / 64'd6)};

    // Stage map
    localparam int ST_T    = 1;
    localparam int ST_T2   = 2;
    localparam int ST_STEP = 3;
    localparam int ST_LASTC = ST_STEP + 3 * N_STEP - 1;
    localparam int ST_F    = ST_LASTC + 1;
    localparam int ST_G    = ST_F + 1;
    localparam int ST_M1   = ST_G + 1;
    localparam int ST_M2   = ST_M1 + 1;
    localparam int ST_M3   = ST_M2 + 1;
    localparam int ST_M4   = ST_M3 + 1;
    localparam int ST_M5   = ST_M4 + 1;
    localparam int N_STG   = ST_M5 + 1;

    // Matrix datapath widths
    localparam int SC_W   = FRAC_BITS + 2;
    localparam int PROD_W = 2 * SC_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic signed [SUM_W-1:0] HALF_LSB  = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] LIM_POS   = SUM_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] LIM_NEG   = -(SUM_W'(1) << FRAC_BITS);

    typedef logic [ANGLE_BITS-1:0]       t_ang;
    typedef logic signed [SC_W-1:0]      t_sc;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [SUM_W-1:0]     t_sum;
    typedef logic [N_ENT-1:0][ENT_W-1:0] t_mat;

    // Round Q0.32 half up to FRAC_BITS
    function automatic logic [FRAC_BITS:0] to_frac(input logic [32:0] x);
        logic [33:0] s;
        s = 34'(x) + ROUND_Q32;
        return s[32 -: FRAC_BITS + 1];
    endfunction

    // Round half toward plus infinity by FRAC_BITS
    function automatic t_sum round_frac(input t_sum v);
        t_sum h;
        h = v + HALF_LSB;
        return h >>> FRAC_BITS;
    endfunction

    // Clamp to +/-1.0 and fit the entry field
    function automatic logic [ENT_W-1:0] sat_ent(input t_sum v);
        t_sum c;
        if (v > LIM_POS) begin
            c = LIM_POS;
        end else if (v < LIM_NEG) begin
            c = LIM_NEG;
        end else begin
            c = v;
        end
        return ENT_W'(c);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/euler_to_rotation_matrix.sv -----
// Throughput: one pose per cycle while the skid is empty, set by the 31-stage
// pipeline of seven three-stage Horner steps (multiply, reciprocal multiply, correct) per angle.
// A skid register after the last stage absorbs one result while i_tready is low.
// Reset (i_rst_n low, synchronous) clears the stage valid bits and the skid.
`default_nettype none

module euler_to_rotation_matrix
    import e2rm_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    // s_axis: roll_angle, pitch_angle, yaw_angle, shift_x, shift_y, shift_z
    input  wire              i_tvalid,
    output logic             o_tready,
    input  wire  [IN_W-1:0]  i_tdata,   // [15:0] roll, [31:16] pitch, [47:32] yaw,
                                        // [79:48] shift_x, [111:80] shift_y,
                                        // [143:112] shift_z
    // m_axis
    output logic             o_tvalid,
    input  wire              i_tready,
    output logic [OUT_W-1:0] o_tdata    // m00,m01,m02,m10,m11,m12,m20,m21,m22 (18b each),
                                        // out_x, out_y, out_z (32b each), zero pad
);

    // Note: the slave-side ready is o_tready and the master-side ready is i_tready,
    // following the i_/o_ direction prefixes.

    // ------------------------------------------------------------------
    // Pipeline control: one global advance while the skid is empty.
    // ------------------------------------------------------------------
    logic              r_v [N_STG];
    logic              r_sk_v;
    logic [OUT_W-1:0]  r_sk_data;
    logic              en;
    logic [OUT_W-1:0]  pipe_data;

    assign en       = !r_sk_v;
    assign o_tready = en;
    assign o_tvalid = r_sk_v || r_v[N_STG-1];
    assign o_tdata  = r_sk_v ? r_sk_data : pipe_data;

    // ------------------------------------------------------------------
    // Per-angle sine/cosine lanes (0 roll, 1 pitch, 2 yaw)
    // ------------------------------------------------------------------
    logic [U_W-1:0]   r_u   [3];
    logic [1:0]       r_qd  [3][0:ST_F];
    logic             r_mir [3][0:ST_F];
    logic [31:0]      r_t   [3][ST_T:ST_LASTC];
    logic [31:0]      r_t2  [3][ST_T2:ST_T2+3*(N_STEP-1)];
    logic [31:0]      r_pc  [3][N_STEP];
    logic [31:0]      r_q0c [3][N_STEP];
    logic [31:0]      r_pbc [3][N_STEP];
    logic [32:0]      r_accc[3][N_STEP];
    logic [31:0]      r_ps  [3][1:6];
    logic [31:0]      r_q0s [3][1:6];
    logic [31:0]      r_pbs [3][1:6];
    logic [32:0]      r_accs[3][1:6];
    logic [FRAC_BITS:0] r_ss [3];
    logic [FRAC_BITS:0] r_cc [3];
    t_sc              r_s   [3];
    t_sc              r_c   [3];

    logic [U_W-1:0]   n_u   [3];
    logic [1:0]       n_qd  [3];
    logic             n_mir [3];
    logic [31:0]      n_t   [3];
    logic [31:0]      n_t2  [3];
    logic [31:0]      n_pc  [3][N_STEP];
    logic [31:0]      n_q0c [3][N_STEP];
    logic [32:0]      n_accc[3][N_STEP];
    logic [31:0]      n_ps  [3][1:6];
    logic [31:0]      n_q0s [3][1:6];
    logic [32:0]      n_accs[3][1:6];
    logic [FRAC_BITS:0] n_ss [3];
    logic [FRAC_BITS:0] n_cc [3];
    t_sc              n_s   [3];
    t_sc              n_c   [3];

    always_comb begin
        t_ang              a;
        logic [U_W-1:0]    rr;
        logic [TP_W-1:0]   tp;
        logic [63:0]       sq;
        logic [64:0]       hp;
        logic [63:0]       mp;
        logic [31:0]       rem;
        logic [31:0]       qq;
        logic [32:0]       acc_in;
        t_sc               ssv;
        t_sc               ccv;
        t_sc               sr;
        t_sc               cr;
        for (int l = 0; l < 3; l++) begin
            // Fold into the first eighth of a turn
            a          = t_ang'(signed'(i_tdata[ANG_IN_W*l +: ANG_IN_W]));
            n_qd[l]    = a[ANGLE_BITS-1 -: 2];
            rr         = a[U_W-1:0];
            n_mir[l]   = rr > EIGHTH;
            n_u[l]     = n_mir[l] ? U_W'(QUARTER - (ANGLE_BITS-1)'(rr)) : rr;

            // Radians in Q0.32
            tp         = TP_W'(r_u[l]) * TWO_PI_Q32 + HALF_UNIT;
            n_t[l]     = tp[ANGLE_BITS +: 32];
            sq         = 64'(r_t[l][ST_T]) * 64'(r_t[l][ST_T]);
            n_t2[l]    = sq[63:32];

            // Cosine Horner steps
            for (int k = 0; k < N_STEP; k++) begin
                acc_in        = (k == 0) ? ONE_Q32 : r_accc[l][(k == 0) ? 0 : k-1];
                hp            = 65'(r_t2[l][ST_T2 + 3*k]) * 65'(acc_in);
                n_pc[l][k]    = hp[63:32];
                mp            = 64'(r_pc[l][k]) * 64'(RCP_COS[k]);
                n_q0c[l][k]   = mp[63:32];
                rem           = r_pbc[l][k] - 32'(r_q0c[l][k] * 32'(DIV_COS[k]));
                qq            = (rem >= 32'(DIV_COS[k])) ? r_q0c[l][k] + 32'd1
                                                         : r_q0c[l][k];
                n_accc[l][k]  = ONE_Q32 - 33'(qq);
            end

            // Sine Horner steps ride alongside cosine steps one to six
            for (int k = 1; k <= 6; k++) begin
                acc_in        = (k == 1) ? ONE_Q32 : r_accs[l][(k == 1) ? 1 : k-1];
                hp            = 65'(r_t2[l][ST_T2 + 3*k]) * 65'(acc_in);
                n_ps[l][k]    = hp[63:32];
                mp            = 64'(r_ps[l][k]) * 64'(RCP_SIN[k]);
                n_q0s[l][k]   = mp[63:32];
                rem           = r_pbs[l][k] - 32'(r_q0s[l][k] * 32'(DIV_SIN[k]));
                qq            = (rem >= 32'(DIV_SIN[k])) ? r_q0s[l][k] + 32'd1
                                                         : r_q0s[l][k];
                n_accs[l][k]  = ONE_Q32 - 33'(qq);
            end

            // Final sine multiply, round both to FRAC_BITS
            hp         = 65'(r_t[l][ST_LASTC]) * 65'(r_accs[l][6]);
            n_ss[l]    = to_frac({1'b0, hp[63:32]});
            n_cc[l]    = to_frac(r_accc[l][N_STEP-1]);

            // Undo mirror and quadrant
            ssv        = t_sc'(signed'({1'b0, r_ss[l]}));
            ccv        = t_sc'(signed'({1'b0, r_cc[l]}));
            sr         = r_mir[l][ST_F] ? ccv : ssv;
            cr         = r_mir[l][ST_F] ? ssv : ccv;
            unique case (r_qd[l][ST_F])
                2'd0: begin n_s[l] = sr;  n_c[l] = cr;  end
                2'd1: begin n_s[l] = cr;  n_c[l] = -sr; end
                2'd2: begin n_s[l] = -sr; n_c[l] = -cr; end
                default: begin n_s[l] = -cr; n_c[l] = sr; end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Matrix stages
    // ------------------------------------------------------------------
    t_prod r_p_czsy, r_p_szsy, r_p_czcy, r_p_szcy, r_p_cysx, r_p_cycx;
    t_sc   r_sx1, r_cx1, r_sy1, r_sz1, r_cz1;
    t_sc   r_czsy, r_szsy, r_sx2, r_cx2, r_sz2, r_cz2;
    t_prod r_p01a, r_p01b, r_p02a, r_p02b, r_p11a, r_p11b, r_p12a, r_p12b;
    t_sum  r_s01, r_s02, r_s11, r_s12;
    t_mat  r_ent2, r_ent3, r_ent4, r_ent5;
    t_mat  n_ent2, n_ent5;
    logic [TR_W-1:0] r_tr [N_STG];

    always_comb begin
        n_ent2    = '0;
        n_ent2[0] = sat_ent(round_frac(t_sum'(r_p_czcy)));
        n_ent2[3] = sat_ent(round_frac(t_sum'(r_p_szcy)));
        n_ent2[6] = sat_ent(-t_sum'(r_sy1));
        n_ent2[7] = sat_ent(round_frac(t_sum'(r_p_cysx)));
        n_ent2[8] = sat_ent(round_frac(t_sum'(r_p_cycx)));

        n_ent5    = r_ent4;
        n_ent5[1] = sat_ent(round_frac(r_s01));
        n_ent5[2] = sat_ent(round_frac(r_s02));
        n_ent5[4] = sat_ent(round_frac(r_s11));
        n_ent5[5] = sat_ent(round_frac(r_s12));
    end

    assign pipe_data = OUT_W'({r_tr[N_STG-1], r_ent5});

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_STG; i++) begin
                r_v[i] <= 1'b0;
            end
            r_sk_v <= 1'b0;
        end else begin
            if (en) begin
                r_v[0] <= i_tvalid;
                for (int i = 1; i < N_STG; i++) begin
                    r_v[i] <= r_v[i-1];
                end
                // Park the last result when the sink stalls
                r_sk_v <= r_v[N_STG-1] && !i_tready;
            end else if (i_tready) begin
                r_sk_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sk_data <= pipe_data;

            r_tr[0] <= i_tdata[3*ANG_IN_W +: TR_W];
            for (int i = 1; i < N_STG; i++) begin
                r_tr[i] <= r_tr[i-1];
            end

            for (int l = 0; l < 3; l++) begin
                r_u[l]      <= n_u[l];
                r_qd[l][0]  <= n_qd[l];
                r_mir[l][0] <= n_mir[l];
                for (int i = 1; i <= ST_F; i++) begin
                    r_qd[l][i]  <= r_qd[l][i-1];
                    r_mir[l][i] <= r_mir[l][i-1];
                end
                r_t[l][ST_T] <= n_t[l];
                for (int i = ST_T + 1; i <= ST_LASTC; i++) begin
                    r_t[l][i] <= r_t[l][i-1];
                end
                r_t2[l][ST_T2] <= n_t2[l];
                for (int i = ST_T2 + 1; i <= ST_T2 + 3*(N_STEP-1); i++) begin
                    r_t2[l][i] <= r_t2[l][i-1];
                end
                for (int k = 0; k < N_STEP; k++) begin
                    r_pc[l][k]   <= n_pc[l][k];
                    r_q0c[l][k]  <= n_q0c[l][k];
                    r_pbc[l][k]  <= r_pc[l][k];
                    r_accc[l][k] <= n_accc[l][k];
                end
                for (int k = 1; k <= 6; k++) begin
                    r_ps[l][k]   <= n_ps[l][k];
                    r_q0s[l][k]  <= n_q0s[l][k];
                    r_pbs[l][k]  <= r_ps[l][k];
                    r_accs[l][k] <= n_accs[l][k];
                end
                r_ss[l] <= n_ss[l];
                r_cc[l] <= n_cc[l];
                r_s[l]  <= n_s[l];
                r_c[l]  <= n_c[l];
            end

            // M1: first products (x = roll, y = pitch, z = yaw)
            r_p_czsy <= t_prod'(r_c[2]) * t_prod'(r_s[1]);
            r_p_szsy <= t_prod'(r_s[2]) * t_prod'(r_s[1]);
            r_p_czcy <= t_prod'(r_c[2]) * t_prod'(r_c[1]);
            r_p_szcy <= t_prod'(r_s[2]) * t_prod'(r_c[1]);
            r_p_cysx <= t_prod'(r_c[1]) * t_prod'(r_s[0]);
            r_p_cycx <= t_prod'(r_c[1]) * t_prod'(r_c[0]);
            r_sx1    <= r_s[0];
            r_cx1    <= r_c[0];
            r_sy1    <= r_s[1];
            r_sz1    <= r_s[2];
            r_cz1    <= r_c[2];

            // M2: round the shared factors, finish the one- and two-factor entries
            r_czsy <= t_sc'(round_frac(t_sum'(r_p_czsy)));
            r_szsy <= t_sc'(round_frac(t_sum'(r_p_szsy)));
            r_sx2  <= r_sx1;
            r_cx2  <= r_cx1;
            r_sz2  <= r_sz1;
            r_cz2  <= r_cz1;
            r_ent2 <= n_ent2;

            // M3: three-factor products
            r_p01a <= t_prod'(r_czsy) * t_prod'(r_sx2);
            r_p01b <= t_prod'(r_sz2)  * t_prod'(r_cx2);
            r_p02a <= t_prod'(r_czsy) * t_prod'(r_cx2);
            r_p02b <= t_prod'(r_sz2)  * t_prod'(r_sx2);
            r_p11a <= t_prod'(r_szsy) * t_prod'(r_sx2);
            r_p11b <= t_prod'(r_cz2)  * t_prod'(r_cx2);
            r_p12a <= t_prod'(r_szsy) * t_prod'(r_cx2);
            r_p12b <= t_prod'(r_cz2)  * t_prod'(r_sx2);
            r_ent3 <= r_ent2;

            // M4: sums at full precision
            r_s01  <= t_sum'(r_p01a) - t_sum'(r_p01b);
            r_s02  <= t_sum'(r_p02a) + t_sum'(r_p02b);
            r_s11  <= t_sum'(r_p11a) + t_sum'(r_p11b);
            r_s12  <= t_sum'(r_p12a) - t_sum'(r_p12b);
            r_ent4 <= r_ent3;

            // M5: round once, clamp
            r_ent5 <= n_ent5;
        end
    end

endmodule

`default_nettype wire
